// ----- sv/rdq_pkg.sv -----
package rdq_pkg;

  // queue geometry
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = ADDR_W + 1;
  localparam int unsigned DATA_W  = 32;

  // field widths of the stream ports
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned ELEM_CNT_W  = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [DATA_W-1:0]  data_t;

  // request opcodes; the two unused codes act as no-op
  typedef enum logic [OPCODE_W-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REVERSE    = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_FETCH,
    S_LOAD
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic apply_op;
    logic load_result;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // circular add of two indexes that are both below DEPTH
  function automatic addr_t wrap_add(addr_t a, addr_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return addr_t'(s);
  endfunction

endpackage

// ----- sv/rdq_ram.sv -----
module rdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- sv/rdq_datapath.sv -----
module rdq_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rdq_pkg::dp_cmd_t                      cmd_i,
  output rdq_pkg::dp_status_t                   status_o,
  input  logic [rdq_pkg::OPCODE_W-1:0]          opcode_i,
  input  logic signed [rdq_pkg::DATA_W-1:0]     push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rdq_pkg::DATA_W-1:0]     front_value_o,
  output logic signed [rdq_pkg::DATA_W-1:0]     back_value_o,
  output logic [rdq_pkg::ELEM_CNT_W-1:0]        element_count_o,
  output logic [rdq_pkg::STATUS_W-1:0]          result_status_o
);

  // latched request
  rdq_pkg::op_e     op_q;
  rdq_pkg::data_t   val_q;

  // queue pointers and flag
  rdq_pkg::addr_t   head_q, head_d;
  rdq_pkg::count_t  occ_q, occ_d;
  logic             rev_q, rev_d;
  rdq_pkg::status_e stat_q, stat_d;

  // memory port
  logic             we;
  rdq_pkg::addr_t   waddr;
  rdq_pkg::addr_t   tail_addr;
  rdq_pkg::data_t   head_data, tail_data;

  // output register
  logic             out_valid_q;
  rdq_pkg::data_t   front_q, back_q;
  logic [rdq_pkg::ELEM_CNT_W-1:0] count_q;
  rdq_pkg::status_e res_stat_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= rdq_pkg::op_e'(opcode_i);
      val_q <= rdq_pkg::data_t'(push_value_i);
    end
  end

  // apply the operation to pointers and storage
  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    rev_d  = rev_q;
    stat_d = stat_q;
    we     = 1'b0;
    waddr  = head_q;
    if (cmd_i.apply_op) begin
      stat_d = rdq_pkg::STAT_OK;
      case (op_q)
        rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
          if (occ_q == rdq_pkg::count_t'(rdq_pkg::DEPTH)) begin
            stat_d = rdq_pkg::STAT_PUSH_FULL;
          end else if ((op_q == rdq_pkg::OP_PUSH_FRONT) != rev_q) begin
            // new element at the physical head
            head_d = (head_q == '0) ? rdq_pkg::addr_t'(rdq_pkg::DEPTH - 1)
                                    : head_q - rdq_pkg::addr_t'(1);
            waddr  = head_d;
            we     = 1'b1;
            occ_d  = occ_q + rdq_pkg::count_t'(1);
          end else begin
            // new element past the physical tail
            waddr = rdq_pkg::wrap_add(head_q, rdq_pkg::addr_t'(occ_q));
            we    = 1'b1;
            occ_d = occ_q + rdq_pkg::count_t'(1);
          end
        end
        rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
          if (occ_q == '0) begin
            stat_d = rdq_pkg::STAT_POP_EMPTY;
          end else if ((op_q == rdq_pkg::OP_POP_FRONT) != rev_q) begin
            head_d = rdq_pkg::wrap_add(head_q, rdq_pkg::addr_t'(1));
            occ_d  = occ_q - rdq_pkg::count_t'(1);
          end else begin
            occ_d = occ_q - rdq_pkg::count_t'(1);
          end
        end
        rdq_pkg::OP_REVERSE: begin
          rev_d = ~rev_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      rev_q  <= 1'b0;
      stat_q <= rdq_pkg::STAT_OK;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
      rev_q  <= rev_d;
      stat_q <= stat_d;
    end
  end

  // physical tail position, only meaningful when not empty
  assign tail_addr = (occ_q == '0) ? head_q
                   : rdq_pkg::wrap_add(head_q, rdq_pkg::addr_t'(occ_q - rdq_pkg::count_t'(1)));

  rdq_ram #(
    .WIDTH (rdq_pkg::DATA_W),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_storage (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (val_q),
    .raddr_a_i (head_q),
    .raddr_b_i (tail_addr),
    .rdata_a_o (head_data),
    .rdata_b_o (tail_data)
  );

  // result register, held until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      if (occ_q == '0) begin
        front_q <= '1;
        back_q  <= '1;
      end else begin
        front_q <= rev_q ? tail_data : head_data;
        back_q  <= rev_q ? head_data : tail_data;
      end
      count_q    <= rdq_pkg::ELEM_CNT_W'(occ_q);
      res_stat_q <= stat_q;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign front_value_o     = $signed(front_q);
  assign back_value_o      = $signed(back_q);
  assign element_count_o   = count_q;
  assign result_status_o   = res_stat_q;

endmodule

// ----- sv/rdq_ctrl.sv -----
module rdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output rdq_pkg::dp_cmd_t    cmd_o,
  input  rdq_pkg::dp_status_t status_i
);

  rdq_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      rdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = rdq_pkg::S_UPDATE;
        end
      end
      rdq_pkg::S_UPDATE: begin
        cmd_o.apply_op = 1'b1;
        state_d        = rdq_pkg::S_FETCH;
      end
      rdq_pkg::S_FETCH: begin
        // memory read of head and tail lands at the end of this cycle
        state_d = rdq_pkg::S_LOAD;
      end
      rdq_pkg::S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = rdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/reversible_deque.sv -----
// Bounded double-ended queue of signed 32-bit values in a 16-entry circular
// buffer, with a reverse request that swaps the logical front and back in
// constant time. Each request (tuser opcode: none, push front, push back,
// pop front, pop back, reverse) gives one result with the logical front and
// back values (-1 when empty), the element count and a status (ok, pop on
// empty ignored, push on full ignored). One request is handled at a time, in
// order: the accepting cycle, which captures it, the pointer update and
// buffer write, the registered two-port buffer read of head and tail, and the
// load of the output register, after which the result is valid and a new
// request can be taken. The next request is accepted while a result waits to
// be taken; a result not taken stalls the following one in its load step.
module reversible_deque (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] front_value, [63:32] back_value,
                                      // [68:64] element_count, [71:69] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  rdq_pkg::dp_cmd_t    cmd;
  rdq_pkg::dp_status_t dp_status;

  logic signed [rdq_pkg::DATA_W-1:0] front_value;
  logic signed [rdq_pkg::DATA_W-1:0] back_value;
  logic [rdq_pkg::ELEM_CNT_W-1:0]    element_count;

  // controller
  rdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (dp_status)
  );

  // pointers, storage and result register
  rdq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .opcode_i        (s_axis_tuser),
    .push_value_i    ($signed(s_axis_tdata)),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .front_value_o   (front_value),
    .back_value_o    (back_value),
    .element_count_o (element_count),
    .result_status_o (m_axis_tuser)
  );

  // result packing
  assign m_axis_tdata = {3'b000, element_count, back_value, front_value};

endmodule

// ----- dv/reversible_deque_tb.sv -----
module reversible_deque_tb;
  import rdq_pkg::*;

  localparam int unsigned PAD_LSB        = 2 * DATA_W + ELEM_CNT_W;
  localparam int unsigned RANDOM_REQS    = 420;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // the two unused opcodes, which the block treats as no-op
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam data_t NEG_ONE = '1;
  localparam data_t INT_MIN = 32'h8000_0000;
  localparam data_t INT_MAX = 32'h7fff_ffff;

  typedef struct packed {
    data_t                 front;
    data_t                 back;
    logic [ELEM_CNT_W-1:0] count;
    status_e               status;
  } deque_result_t;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    data_t               value;
    int unsigned         reps;
    bit                  typed;
    deque_result_t       want;
  } dir_row_t;

  typedef enum {SINK_OPEN, SINK_MASK, SINK_RANDOM} sink_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic [OPCODE_W-1:0]    s_axis_tuser = OP_NONE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  // shadow copy of the deque
  data_t       slots [DEPTH];
  int unsigned head_pos = 0;
  int unsigned fill_level = 0;
  bit          flipped = 1'b0;

  deque_result_t pending_results [$];
  dir_row_t      directed_rows [$];

  int unsigned mismatch_count = 0;
  int unsigned request_count = 0;
  int unsigned result_count = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  reversible_deque DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one request against the shadow deque, gives the result it should report
  function automatic deque_result_t apply_deque_op(logic [OPCODE_W-1:0] op, data_t value);
    deque_result_t r;
    data_t         at_head;
    data_t         at_tail;
    r.status = STAT_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = STAT_PUSH_FULL;
        end else if ((op == OP_PUSH_FRONT) != flipped) begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          slots[head_pos] = value;
          fill_level++;
        end else begin
          slots[(head_pos + fill_level) % DEPTH] = value;
          fill_level++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = STAT_POP_EMPTY;
        end else if ((op == OP_POP_FRONT) != flipped) begin
          head_pos = (head_pos + 1) % DEPTH;
          fill_level--;
        end else begin
          fill_level--;
        end
      end
      OP_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
      end
    endcase
    // logical ends follow the flag
    if (fill_level == 0) begin
      r.front = NEG_ONE;
      r.back  = NEG_ONE;
    end else begin
      at_head = slots[head_pos];
      at_tail = slots[(head_pos + fill_level - 1) % DEPTH];
      r.front = flipped ? at_tail : at_head;
      r.back  = flipped ? at_head : at_tail;
    end
    r.count = fill_level[ELEM_CNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [OPCODE_W-1:0] op, input data_t value,
                         input int unsigned reps, input bit typed, input data_t front,
                         input data_t back, input int unsigned count, input status_e status);
    dir_row_t row;
    row.op = op;
    row.value = value;
    row.reps = reps;
    row.typed = typed;
    row.want.front = front;
    row.want.back = back;
    row.want.count = count[ELEM_CNT_W-1:0];
    row.want.status = status;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // offer one request, wait for it to be taken, then queue what it should give
  task automatic send_request(input logic [OPCODE_W-1:0] op, input data_t value,
                              input bit use_row, input deque_result_t row_want);
    deque_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_deque_op(op, value);
    pending_results.insert(pending_results.size(), use_row ? row_want : predicted);
    request_count++;
    if (predicted.status == STAT_PUSH_FULL) full_hits++;
    if (predicted.status == STAT_POP_EMPTY) empty_hits++;
    // bursts and gaps, no gaps while the sink is held off
    if (burst_left > 0) begin
      burst_left--;
    end else if (!(hold_req && !hold_done)) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= OPCODE_W'($urandom());
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tdata[DATA_W-1:0] !== want.front)
          report_mismatch($sformatf("result %0d front %h, want %h", result_count,
                                    m_axis_tdata[DATA_W-1:0], want.front));
        if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.back)
          report_mismatch($sformatf("result %0d back %h, want %h", result_count,
                                    m_axis_tdata[2*DATA_W-1:DATA_W], want.back));
        if (m_axis_tdata[PAD_LSB-1:2*DATA_W] !== want.count)
          report_mismatch($sformatf("result %0d count %0d, want %0d", result_count,
                                    m_axis_tdata[PAD_LSB-1:2*DATA_W], want.count));
        if (m_axis_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
          report_mismatch($sformatf("result %0d pad bits %b", result_count,
                                    m_axis_tdata[OUT_TDATA_W-1:PAD_LSB]));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d", result_count,
                                    m_axis_tuser, want.status));
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : sink_stall
    sink_mode_e  mode;
    logic [7:0]  stall_mask;
    int unsigned seg_len;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 2));
      seg_len = $urandom_range(16, 64);
      stall_mask = 8'($urandom()) | 8'h01;
      for (int unsigned i = 0; i < seg_len; i++) begin
        @(posedge clk_i);
        if (hold_req && !hold_done) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(posedge clk_i);
          hold_done = 1'b1;
        end else begin
          case (mode)
            SINK_OPEN: m_axis_tready <= 1'b1;
            SINK_MASK: m_axis_tready <= stall_mask[i % 8];
            default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("reversible_deque_tb: done, errors");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    deque_result_t       no_want;
    logic [OPCODE_W-1:0] op;
    data_t               value;
    int unsigned         pick;
    int unsigned         push_share;
    bit                  fill_bias;
    no_want = '0;
    fill_bias = 1'b1;

    // empty queue cases, reverse on empty, unused opcodes
    add_row(OP_POP_FRONT,  '0, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_POP_EMPTY);
    add_row(OP_POP_BACK,   '0, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_POP_EMPTY);
    add_row(OP_REVERSE,    '0, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_OK);
    add_row(OP_NONE,  NEG_ONE, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_OK);
    add_row(OP_SPARE_6, INT_MAX, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_OK);
    add_row(OP_SPARE_7, INT_MIN, 1, 1, NEG_ONE, NEG_ONE, 0, STAT_OK);
    // reversed pushes with extreme values
    add_row(OP_PUSH_FRONT, INT_MIN, 1, 1, INT_MIN, INT_MIN, 1, STAT_OK);
    add_row(OP_PUSH_BACK,  INT_MAX, 1, 1, INT_MIN, INT_MAX, 2, STAT_OK);
    add_row(OP_REVERSE,    '0,      1, 0, '0, '0, 0, STAT_OK);
    add_row(OP_POP_FRONT,  '0,      1, 0, '0, '0, 0, STAT_OK);
    add_row(OP_POP_BACK,   '0,      1, 0, '0, '0, 0, STAT_OK);
    // fill to the brim, then push on full
    add_row(OP_PUSH_FRONT, 32'h0123_4567, DEPTH, 0, '0, '0, 0, STAT_OK);
    add_row(OP_PUSH_BACK,  NEG_ONE, 1, 0, '0, '0, 0, STAT_OK);
    add_row(OP_PUSH_FRONT, '0,      1, 0, '0, '0, 0, STAT_OK);
    add_row(OP_POP_BACK,   '0,      1, 0, '0, '0, 0, STAT_OK);
    add_row(OP_POP_FRONT,  '0,      1, 0, '0, '0, 0, STAT_OK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
        send_request(directed_rows[r].op, directed_rows[r].value + k * 32'h1111_1111,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // random part, swinging between filling and draining
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0) fill_bias = $urandom_range(0, 1);
      if (i == RANDOM_REQS / 2) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      push_share = fill_bias ? 65 : 30;
      if (pick < push_share) op = pick[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (pick < 85)    op = pick[0] ? OP_POP_FRONT : OP_POP_BACK;
      else if (pick < 94)    op = OP_REVERSE;
      else if (pick < 96)    op = OP_NONE;
      else if (pick < 98)    op = OP_SPARE_6;
      else                   op = OP_SPARE_7;
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = NEG_ONE;
        2:       value = INT_MIN;
        3:       value = INT_MAX;
        default: value = $urandom();
      endcase
      send_request(op, value, 1'b0, no_want);
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results, including a long sink hold-off",
             request_count, result_count);
    $display("push on full hit %0d times, pop on empty hit %0d times",
             full_hits, empty_hits);
    if (mismatch_count == 0) begin
      $display("reversible_deque_tb: done, clean");
    end else begin
      $display("reversible_deque_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rdq_pkg.sv
sv/rdq_ram.sv
sv/rdq_datapath.sv
sv/rdq_ctrl.sv
sv/reversible_deque.sv
dv/reversible_deque_tb.sv
